// File: hw/rtl/bfiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared constants for the Bloom filter insert and query core.
// ----------------------------------------------------------------------------
package bfiq_pkg;

	localparam int KEY_W      = 64;
	localparam int WORD_W     = 64;
	localparam int BIT_SEL_W  = 6;
	localparam int STEP_W     = 7;

	localparam int BC_W       = 18;
	localparam int HC_W       = 11;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = CFG_IDX_W'(1);

	localparam logic [BC_W-1:0] BIT_COUNT_RST  = BC_W'(131072);
	localparam logic [HC_W-1:0] HASH_COUNT_RST = HC_W'(8);

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

endpackage

// File: hw/rtl/bfiq_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_mod
// Restoring remainder unit: shifts dividend bits into a running remainder,
// one bit per cycle, reducing by the modulus at every step.
// ----------------------------------------------------------------------------
module bfiq_mod import bfiq_pkg::*; #(
	parameter int MW = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MW-1:0]     rem_init,
	input  logic [KEY_W-1:0]  dvd,
	input  logic [STEP_W-1:0] steps,
	input  logic [MW-1:0]     modulus,
	output logic              done,
	output logic [MW-1:0]     rem
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [MW-1:0]     rem_q;
	logic [MW:0]       trial;
	logic [MW:0]       diff;
	logic [MW-1:0]     rem_next;

	assign trial    = {rem_q, dvd_q[KEY_W-1]};
	assign diff     = trial - {1'b0, modulus};
	assign rem_next = (trial >= {1'b0, modulus}) ? diff[MW-1:0] : trial[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dvd;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hw/rtl/bfiq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_mem
// Filter bit store, organized as 64-bit rows with a registered read port and
// a write port. After reset a clearing pass zeroes one row per cycle.
// ----------------------------------------------------------------------------
module bfiq_mem import bfiq_pkg::*; #(
	parameter int WORDS = 2048,
	parameter int RW    = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [RW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [RW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic              clearing
);

	logic [WORD_W-1:0] mem_q [WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic              clearing_q;
	logic [RW-1:0]     clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + RW'(1);
			if (clr_cnt_q == RW'(WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// File: hw/rtl/bloom_filter_insert_query_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_core
// Bloom filter insert and query over a cleared bit store.
// Busy stays high while an accepted item is worked on; one shared
// bit-serial remainder unit reduces the key's high bits and then each
// probe in turn. The query result strobes in the first cycle with busy
// low, which cannot be stalled, and the next item can be accepted in that
// cycle, not before. After reset, busy stays high while the store is
// cleared row by row.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_core import bfiq_pkg::*; #(
	parameter int BIT_CAPACITY = 131072,
	parameter int MAX_PROBES   = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  logic [KEY_W-1:0]      key_hash,
	output logic                  result_valid,
	output logic                  present,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WORDS = (BIT_CAPACITY + WORD_W - 1) / WORD_W;
	localparam int RW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int MW    = $clog2(BIT_CAPACITY + 1);
	localparam int LO_W  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
	localparam int PW    = $clog2(MAX_PROBES + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HI_GO = 3'd1;
	localparam logic [2:0] ST_HI    = 3'd2;
	localparam logic [2:0] ST_LO_GO = 3'd3;
	localparam logic [2:0] ST_LO    = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_CHK   = 3'd6;

	logic [2:0]        st_q;
	logic [BC_W-1:0]   bit_count_q;
	logic [HC_W-1:0]   hash_count_q;
	logic              mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [PW-1:0]     probe_q;
	logic [MW-1:0]     rem_hi_q;
	logic              all_set_q;
	logic              result_valid_q;
	logic              present_q;

	logic [MW-1:0]     modulus;
	logic [PW-1:0]     eff_probes;
	logic              accept;
	logic              clearing;
	logic              mod_start;
	logic [MW-1:0]     mod_init;
	logic [KEY_W-1:0]  mod_dvd;
	logic [STEP_W-1:0] mod_steps;
	logic              mod_done;
	logic [MW-1:0]     mod_rem;
	logic [RW-1:0]     row;
	logic [BIT_SEL_W-1:0] bit_sel;
	logic [WORD_W-1:0] rd_data;
	logic              hit;
	logic              mem_wr;
	logic [PW-1:0]     probe_next;
	logic [LO_W-1:0]   lo_bits;

	always_comb begin
		if (bit_count_q == '0) begin
			modulus = MW'(1);
		end else if (32'(bit_count_q) > BIT_CAPACITY) begin
			modulus = MW'(BIT_CAPACITY);
		end else begin
			modulus = MW'(bit_count_q);
		end
		if (32'(hash_count_q) > MAX_PROBES) begin
			eff_probes = PW'(MAX_PROBES);
		end else begin
			eff_probes = PW'(hash_count_q);
		end
	end

	assign accept     = start && !busy;
	assign busy       = (st_q != ST_IDLE) || clearing;
	assign cfg_ready  = 1'b1;
	assign lo_bits    = key_q[LO_W-1:0] ^ probe_q[LO_W-1:0];
	assign probe_next = probe_q + PW'(1);
	assign row        = RW'(mod_rem >> BIT_SEL_W);
	assign bit_sel    = mod_rem[BIT_SEL_W-1:0];
	assign hit        = rd_data[bit_sel];
	assign mem_wr     = (st_q == ST_CHK) && (mode_q == MODE_INSERT);

	always_comb begin
		mod_start = 1'b0;
		mod_init  = '0;
		mod_dvd   = {key_q[KEY_W-1:LO_W], LO_W'(0)};
		mod_steps = STEP_W'(KEY_W - LO_W);
		case (st_q)
			ST_HI_GO: begin
				mod_start = 1'b1;
			end
			ST_LO_GO: begin
				mod_start = 1'b1;
				mod_init  = rem_hi_q;
				mod_dvd   = {lo_bits, (KEY_W - LO_W)'(0)};
				mod_steps = STEP_W'(LO_W);
			end
			default: begin
				mod_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= BIT_COUNT_RST;
			hash_count_q <= HASH_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BIT_COUNT) begin
				bit_count_q <= cfg_data[BC_W-1:0];
			end else if (cfg_index == REG_HASH_COUNT) begin
				hash_count_q <= cfg_data[HC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_HI_GO;
					end
				end
				ST_HI_GO: begin
					st_q <= ST_HI;
				end
				ST_HI: begin
					if (mod_done) begin
						if (eff_probes == '0) begin
							st_q           <= ST_IDLE;
							result_valid_q <= (mode_q == MODE_QUERY);
						end else begin
							st_q <= ST_LO_GO;
						end
					end
				end
				ST_LO_GO: begin
					st_q <= ST_LO;
				end
				ST_LO: begin
					if (mod_done) begin
						st_q <= ST_RD;
					end
				end
				ST_RD: begin
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					if (probe_next == eff_probes) begin
						st_q           <= ST_IDLE;
						result_valid_q <= (mode_q == MODE_QUERY);
					end else begin
						st_q <= ST_LO_GO;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode;
			key_q     <= key_hash;
			probe_q   <= '0;
			all_set_q <= 1'b1;
		end
		if ((st_q == ST_HI) && mod_done) begin
			rem_hi_q <= mod_rem;
			if (eff_probes == '0) begin
				present_q <= 1'b1;
			end
		end
		if (st_q == ST_CHK) begin
			probe_q   <= probe_next;
			all_set_q <= all_set_q & hit;
			present_q <= all_set_q & hit;
		end
	end

	assign result_valid = result_valid_q;
	assign present      = present_q;

	bfiq_mod #(
		.MW(MW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.rem_init (mod_init),
		.dvd      (mod_dvd),
		.steps    (mod_steps),
		.modulus  (modulus),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	bfiq_mem #(
		.WORDS(WORDS),
		.RW   (RW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (st_q == ST_RD),
		.rd_addr  (row),
		.rd_data  (rd_data),
		.wr_en    (mem_wr),
		.wr_addr  (row),
		.wr_data  (rd_data | (WORD_W'(1) << bit_sel)),
		.clearing (clearing)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bloom filter insert and query core.
// A short table of directed beats covers empty and full keys, zero and
// oversized bit counts, zero and oversized probe counts, truncated and
// ignored register writes. It is followed by random phases: each one picks a
// new configuration and then mixes inserts with queries of keys already
// inserted, fresh random keys and single-bit keys. A bit-level copy of the
// filter predicts each query answer that the table does not fix, and answers are checked in order.
// ----------------------------------------------------------------------------
module tb import bfiq_pkg::*; ();

	localparam int BIT_CAPACITY = 131072;
	localparam int MAX_PROBES   = 1024;
	localparam int RANDOM_ITEMS = 1700;
	localparam int LIMIT_CYCLES = 4000000;
	localparam int MAX_LINES    = 40;
	localparam int NONE         = -1;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

	typedef struct {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		logic                  op;
		logic [KEY_W-1:0]      key;
		int                    want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  mode = MODE_INSERT;
	logic [KEY_W-1:0]      key_hash = '0;
	logic                  result_valid;
	logic                  present;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    pinned = NONE;

	bit                    filter_q [BIT_CAPACITY];
	logic [BC_W-1:0]       bits_q = BIT_COUNT_RST;
	logic [HC_W-1:0]       probes_q = HASH_COUNT_RST;
	logic                  answers [$];
	script_row_t           script [$];
	int                    errors = 0;
	int                    answered = 0;
	int                    sent = 0;
	int                    cycles = 0;
	int                    burst_left = 0;
	bit                    fresh_items = 1'b0;

	bloom_filter_insert_query_core #(
		.BIT_CAPACITY(BIT_CAPACITY),
		.MAX_PROBES  (MAX_PROBES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.key_hash    (key_hash),
		.result_valid(result_valid),
		.present     (present),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		if (errors <= MAX_LINES)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic void add_row(input script_row_t row);
		script.insert(script.size(), row);
	endfunction

	function automatic int live_probes();
		return (probes_q > MAX_PROBES) ? MAX_PROBES : int'(probes_q);
	endfunction

	// Walks the probe sequence of one key, setting bits on an insert and
	// returning whether every probed bit is set on a query.
	function automatic logic probe_filter(input logic op, input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] modulus;
		logic [KEY_W-1:0] slot;
		logic             all_set;
		modulus = (bits_q == 0) ? KEY_W'(1) :
			(bits_q > BIT_CAPACITY) ? KEY_W'(BIT_CAPACITY) : KEY_W'(bits_q);
		all_set = 1'b1;
		for (int i = 0; i < live_probes(); i++) begin
			slot = (key ^ KEY_W'(i)) % modulus;
			if (op == MODE_INSERT)
				filter_q[slot] = 1'b1;
			else if (!filter_q[slot])
				all_set = 1'b0;
		end
		return all_set;
	endfunction

	function automatic int settle_cycles();
		return 80 + live_probes() * 16;
	endfunction

	always @(posedge clk) begin : scoreboard
		logic want;
		logic got;
		if (arst_n) begin
			if (result_valid === 1'b1) begin
				answered++;
				if (answers.size() == 0) begin
					report($sformatf("answer %0d arrived with no query waiting", answered));
				end else begin
					want = answers.pop_front();
					if (present !== want)
						report($sformatf("answer %0d: present %b, expected %b",
							answered, present, want));
				end
			end
			if (cfg_valid && cfg_ready === 1'b1) begin
				if (cfg_index == REG_BIT_COUNT)
					bits_q = cfg_data[BC_W-1:0];
				else if (cfg_index == REG_HASH_COUNT)
					probes_q = cfg_data[HC_W-1:0];
			end
			if (start && busy === 1'b0) begin
				got = probe_filter(mode, key_hash);
				if (mode == MODE_QUERY)
					answers.insert(answers.size(), (pinned >= 0) ? pinned[0] : got);
			end
		end
	end

	task automatic put_item(input logic op, input logic [KEY_W-1:0] key, input int want);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
				$urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		mode <= op;
		key_hash <= key;
		pinned <= want;
		do @(posedge clk); while (busy !== 1'b0);
		sent++;
		fresh_items = 1'b1;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		while (answers.size() != 0) @(posedge clk);
		if (fresh_items) begin
			repeat (settle_cycles()) @(posedge clk);
			fresh_items = 1'b0;
		end
		while (busy !== 1'b0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		@(posedge clk);
		burst_left = 0;
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] bc_val;
		logic [CFG_DATA_W-1:0] hc_val;
		logic [KEY_W-1:0]      k;
		logic [KEY_W-1:0]      keep [$];
		int                    n;
		int                    goal;
		int                    heavy_phases;

		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h0, 0});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  '1, 0});
		add_row('{ROW_ITEM,  '0, '0, MODE_INSERT, 64'h0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h0, 1});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  '1, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_INSERT, '1, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  '1, 1});
		add_row('{ROW_WRITE, REG_BIT_COUNT, '0, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h0123_4567_89AB_CDEF, 1});
		add_row('{ROW_WRITE, REG_BIT_COUNT, '1, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h8000_0000_0000_0000, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_INSERT, 64'h8000_0000_0000_0000, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h8000_0000_0000_0000, 1});
		add_row('{ROW_WRITE, REG_HASH_COUNT, '0, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'hDEAD_BEEF_0000_0001, 1});
		add_row('{ROW_ITEM,  '0, '0, MODE_INSERT, 64'h5555_5555_5555_5555, NONE});
		add_row('{ROW_WRITE, REG_HASH_COUNT, 18'h3F803, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h5555_5555_5555_5555, NONE});
		add_row('{ROW_WRITE, REG_SPARE_LO, '0, MODE_INSERT, '0, NONE});
		add_row('{ROW_WRITE, REG_SPARE_HI, '1, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h0, NONE});
		add_row('{ROW_WRITE, REG_BIT_COUNT, 18'd64, MODE_INSERT, '0, NONE});
		add_row('{ROW_WRITE, REG_HASH_COUNT, 18'h007FF, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1});
		add_row('{ROW_WRITE, REG_BIT_COUNT, 18'd1, MODE_INSERT, '0, NONE});
		add_row('{ROW_WRITE, REG_HASH_COUNT, 18'd1, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  '1, NONE});
		add_row('{ROW_WRITE, REG_BIT_COUNT, 18'(BIT_CAPACITY), MODE_INSERT, '0, NONE});
		add_row('{ROW_WRITE, REG_HASH_COUNT, 18'd8, MODE_INSERT, '0, NONE});
		add_row('{ROW_ITEM,  '0, '0, MODE_QUERY,  64'h2, NONE});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_WRITE)
				write_reg(script[r].index, script[r].data);
			else
				put_item(script[r].op, script[r].key, script[r].want);
		end

		goal = sent + RANDOM_ITEMS;
		heavy_phases = 0;
		while (sent < goal) begin
			case ($urandom_range(0, 7))
				0: bc_val = '0;
				1: bc_val = CFG_DATA_W'($urandom_range(1, 64));
				2: bc_val = CFG_DATA_W'(BIT_CAPACITY);
				3: bc_val = CFG_DATA_W'($urandom_range(BIT_CAPACITY + 1, 2 ** CFG_DATA_W - 1));
				4, 5: bc_val = CFG_DATA_W'($urandom_range(1, 4096));
				default: bc_val = CFG_DATA_W'($urandom_range(1, BIT_CAPACITY));
			endcase
			if (heavy_phases < 3 && $urandom_range(0, 9) == 0) begin
				hc_val = CFG_DATA_W'($urandom_range(200, 2 ** HC_W - 1));
				n = $urandom_range(2, 3);
				heavy_phases++;
			end else begin
				hc_val = ($urandom_range(0, 11) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 12));
				n = $urandom_range(40, 120);
			end
			if ($urandom_range(0, 3) == 0)
				hc_val[CFG_DATA_W-1:HC_W] = (CFG_DATA_W - HC_W)'($urandom);
			write_reg(REG_BIT_COUNT, bc_val);
			write_reg(REG_HASH_COUNT, hc_val);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					CFG_DATA_W'($urandom));
			keep.delete();
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						k = {$urandom, $urandom};
						keep.insert(keep.size(), k);
						put_item(MODE_INSERT, k, NONE);
					end
					4, 5, 6: begin
						k = (keep.size() != 0) ? keep[$urandom_range(0, keep.size() - 1)] :
							{$urandom, $urandom};
						put_item(MODE_QUERY, k, NONE);
					end
					7, 8: put_item(MODE_QUERY, {$urandom, $urandom}, NONE);
					default: begin
						k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
						if ($urandom_range(0, 1) == 1)
							k = ~k;
						put_item(($urandom_range(0, 1) == 1) ? MODE_QUERY : MODE_INSERT, k, NONE);
					end
				endcase
			end
		end

		start <= 1'b0;
		while (answers.size() != 0) @(posedge clk);
		repeat (settle_cycles()) @(posedge clk);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
